/* sv/aoi_pkg.sv */
package aoi_pkg;

    localparam int TableDepth = 32;
    localparam int SlotBits   = 5;
    localparam int CoordBits  = 16;
    localparam int IdBits     = 16;
    localparam int DiffBits   = CoordBits + 1;

    typedef enum logic [2:0] {
        OP_WR_PT   = 3'd0,
        OP_WR_RECT = 3'd1,
        OP_CLEAR   = 3'd2,
        OP_Q_PT    = 3'd3,
        OP_Q_RECT  = 3'd4,
        OP_MV_PT   = 3'd5,
        OP_MV_RECT = 3'd6,
        OP_NONE    = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        EV_HIT   = 3'd0,
        EV_ENTER = 3'd1,
        EV_LEAVE = 3'd2,
        EV_DONE  = 3'd3,
        EV_EMPTY = 3'd4
    } t_event;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_TEST_A,
        S_TEST_B,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input word
        logic write;     // write the table slot
        logic clear;     // clear the table slot
        logic rd;        // read entry at scan index, or the own slot for a clear
        logic sel_b;     // area B drives the distance unit
        logic test_a;    // evaluate area A against the read entry
        logic test_b;    // evaluate area B and emit the scan result
        logic step;      // advance scan index
        logic emit_done; // emit the final word
    } t_cmd;

    // Status back to the controller.
    typedef struct packed {
        logic is_write;
        logic is_clear;
        logic is_scan;
        logic is_move;
        logic scan_last;
    } t_stat;

endpackage

/* sv/aoi_datapath.sv */
module aoi_datapath
    import aoi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic [2:0]           i_op,
    input  logic [4:0]           i_slot,
    input  logic [15:0]          i_entity_id,
    input  logic [15:0]          i_a_min_x,
    input  logic [15:0]          i_a_min_y,
    input  logic [15:0]          i_a_max_x,
    input  logic [15:0]          i_a_max_y,
    input  logic [15:0]          i_b_min_x,
    input  logic [15:0]          i_b_min_y,
    input  logic [15:0]          i_b_max_x,
    input  logic [15:0]          i_b_max_y,
    input  logic [15:0]          i_range,
    output logic                 o_valid,
    output logic [2:0]           o_event_res,
    output logic [15:0]          o_publisher_id,
    output logic [4:0]           o_hit_slot,
    output logic                 o_last
);

    // Captured input word.
    logic [2:0]           r_op;
    logic [SlotBits-1:0]  r_slot;
    logic [IdBits-1:0]    r_id;
    logic [CoordBits-1:0] r_a [4];
    logic [CoordBits-1:0] r_b [4];
    logic [CoordBits-1:0] r_rng;

    // Publisher table: valid bits in flops, the rest in a memory.
    logic [TableDepth-1:0] r_valid;
    logic [IdBits+4*CoordBits:0] r_mem [TableDepth];
    logic [IdBits+4*CoordBits:0] r_rd;
    logic                  r_rd_valid;
    logic [SlotBits-1:0]   r_idx;
    logic [SlotBits-1:0]   r_rd_slot;
    logic                  r_hit_a;

    // Output register.
    logic                 r_ov;
    logic [2:0]           r_oev;
    logic [IdBits-1:0]    r_oid;
    logic [SlotBits-1:0]  r_oslot;
    logic                 r_olast;

    t_op op_q;
    assign op_q = t_op'(r_op);

    assign o_stat.is_write  = (op_q == OP_WR_PT) || (op_q == OP_WR_RECT);
    assign o_stat.is_clear  = (op_q == OP_CLEAR);
    assign o_stat.is_scan   = (op_q == OP_Q_PT) || (op_q == OP_Q_RECT) ||
                              (op_q == OP_MV_PT) || (op_q == OP_MV_RECT);
    assign o_stat.is_move   = (op_q == OP_MV_PT) || (op_q == OP_MV_RECT);
    assign o_stat.scan_last = (r_idx == SlotBits'(TableDepth - 1));

    logic sub_rect;
    assign sub_rect = (op_q == OP_Q_RECT) || (op_q == OP_MV_RECT);

    // Fields of the read entry.
    logic                 e_area;
    logic [IdBits-1:0]    e_id;
    logic [CoordBits-1:0] e_box [4];
    assign e_area   = r_rd[IdBits+4*CoordBits];
    assign e_id     = r_rd[IdBits+4*CoordBits-1 -: IdBits];
    assign e_box[0] = r_rd[4*CoordBits-1 -: CoordBits];
    assign e_box[1] = r_rd[3*CoordBits-1 -: CoordBits];
    assign e_box[2] = r_rd[2*CoordBits-1 -: CoordBits];
    assign e_box[3] = r_rd[CoordBits-1 -: CoordBits];

    // Corner distance squared, registered from the current terms ahead of the compare.
    logic [2*CoordBits+1:0] r_sq, r_rsq;
    logic [CoordBits-1:0]   dx, dy;
    logic                   test_sel_b;
    assign test_sel_b = i_cmd.sel_b;

    // Shared distance unit: one subscriber area against the read entry.
    logic [CoordBits-1:0] s_box [4];
    logic [CoordBits-1:0] px, py, bx0, by0, bx1, by1, cx, cy;
    logic [DiffBits-1:0]  lo_x, lo_y, hi_x, hi_y;
    logic [2*CoordBits+1:0] sq;
    logic in_box, corner, near, hit;
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            s_box[k] = test_sel_b ? r_b[k] : r_a[k];
        end
        if (sub_rect) begin
            px = e_box[0]; py = e_box[1];
            bx0 = s_box[0]; by0 = s_box[1]; bx1 = s_box[2]; by1 = s_box[3];
        end else begin
            px = s_box[0]; py = s_box[1];
            bx0 = e_box[0]; by0 = e_box[1]; bx1 = e_box[2]; by1 = e_box[3];
        end
        // A point publisher under a point subscriber is a degenerate box.
        if (!sub_rect && !e_area) begin
            bx1 = bx0; by1 = by0;
        end
        lo_x = {1'b0, px} + {1'b0, r_rng};
        lo_y = {1'b0, py} + {1'b0, r_rng};
        hi_x = {1'b0, bx1} + {1'b0, r_rng};
        hi_y = {1'b0, by1} + {1'b0, r_rng};
        in_box = (lo_x >= {1'b0, bx0}) && ({1'b0, px} <= hi_x) &&
                 (lo_y >= {1'b0, by0}) && ({1'b0, py} <= hi_y);
        corner = 1'b1;
        cx = bx0; cy = by0;
        if (px <= bx0 && py <= by0) begin
            cx = bx0; cy = by0;
        end else if (px <= bx0 && py >= by1) begin
            cx = bx0; cy = by1;
        end else if (px >= bx1 && py <= by0) begin
            cx = bx1; cy = by0;
        end else if (px >= bx1 && py >= by1) begin
            cx = bx1; cy = by1;
        end else begin
            corner = 1'b0;
        end
        sq = r_sq;
        near = in_box && (!corner || (sq <= r_rsq));
        hit = r_rd_valid && (e_id != r_id) && !(sub_rect && e_area) && near;
    end

    always_comb begin
        dx = (px > cx) ? px - cx : cx - px;
        dy = (py > cy) ? py - cy : cy - py;
    end

    // Sequence per slot: read, square A, test A, square B, test B.
    always_ff @(posedge i_clk) begin
        r_sq  <= (2*CoordBits+2)'(dx * dx) + (2*CoordBits+2)'(dy * dy);
        r_rsq <= (2*CoordBits+2)'(r_rng * r_rng);
    end

    // Table, capture and scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_idx   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_ov    <= 1'b0;
            if (i_cmd.load) begin
                r_idx <= '0;
            end
            if (i_cmd.step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.write) begin
                r_valid[r_slot] <= 1'b1;
            end
            if (i_cmd.clear) begin
                r_valid[r_slot] <= 1'b0;
            end
            if (i_cmd.rd) begin
                r_rd_valid <= r_valid[r_idx];
            end
            if (i_cmd.test_a) begin
                r_hit_a <= hit;
            end
            if (i_cmd.write) begin
                r_ov <= 1'b1;
                r_oev <= EV_DONE; r_oid <= r_id; r_oslot <= r_slot; r_olast <= 1'b1;
            end else if (i_cmd.clear) begin
                r_ov <= 1'b1;
                r_olast <= 1'b1; r_oslot <= r_slot;
                if (r_valid[r_slot]) begin
                    r_oev <= EV_DONE; r_oid <= e_id;
                end else begin
                    r_oev <= EV_EMPTY; r_oid <= '0;
                end
            end else if (i_cmd.test_b) begin
                r_oid <= e_id; r_oslot <= r_rd_slot; r_olast <= 1'b0;
                if (!o_stat.is_move) begin
                    r_ov <= r_hit_a; r_oev <= EV_HIT;
                end else if (r_hit_a && !hit) begin
                    r_ov <= 1'b1; r_oev <= EV_ENTER;
                end else if (hit && !r_hit_a) begin
                    r_ov <= 1'b1; r_oev <= EV_LEAVE;
                end
            end else if (i_cmd.emit_done) begin
                r_ov <= 1'b1;
                r_oev <= EV_DONE; r_oid <= '0; r_oslot <= '0; r_olast <= 1'b1;
            end
        end
    end

    // Payload registers and memory. A clear reads its own slot to get the id.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_op; r_slot <= i_slot; r_id <= i_entity_id; r_rng <= i_range;
            r_a[0] <= i_a_min_x; r_a[1] <= i_a_min_y;
            r_a[2] <= i_a_max_x; r_a[3] <= i_a_max_y;
            r_b[0] <= i_b_min_x; r_b[1] <= i_b_min_y;
            r_b[2] <= i_b_max_x; r_b[3] <= i_b_max_y;
        end
        if (i_cmd.write) begin
            r_mem[r_slot] <= {op_q == OP_WR_RECT, r_id, r_a[0], r_a[1],
                              (op_q == OP_WR_RECT) ? r_a[2] : r_a[0],
                              (op_q == OP_WR_RECT) ? r_a[3] : r_a[1]};
        end
        if (i_cmd.rd) begin
            r_rd      <= r_mem[o_stat.is_clear ? r_slot : r_idx];
            r_rd_slot <= r_idx;
        end
    end

    assign o_valid        = r_ov;
    assign o_event_res    = r_oev;
    assign o_publisher_id = r_oid;
    assign o_hit_slot     = r_oslot;
    assign o_last         = r_olast;

`ifndef SYNTHESIS
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_olast) |-> (r_oev == EV_DONE || r_oev == EV_EMPTY))
        else $error("final word has wrong event");
    a_nolast_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_olast) |-> (r_oev == EV_HIT || r_oev == EV_ENTER ||
                                r_oev == EV_LEAVE))
        else $error("scan word has wrong event");
    a_write_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |=> r_valid[$past(r_slot)])
        else $error("write did not set valid");
`endif

endmodule

/* sv/aoi_ctrl.sv */
module aoi_ctrl
    import aoi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state r_state, n_state;
    logic   r_phase, n_phase;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    // Per slot: READ, TEST_A (square then compare), TEST_B (square then compare).
    always_comb begin
        n_state = r_state;
        n_phase = 1'b0;
        o_cmd   = '0;
        o_busy  = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.is_write) begin
                    o_cmd.write = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.is_clear) begin
                    if (!r_phase) begin
                        o_cmd.rd = 1'b1;
                        o_cmd.clear = 1'b0;
                        n_phase = 1'b1;
                    end else begin
                        o_cmd.clear = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (i_stat.is_scan && !r_phase) begin
                    n_state = S_READ;
                end else begin
                    o_cmd.emit_done = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state = S_TEST_A;
            end
            S_TEST_A: begin
                o_cmd.test_a = r_phase;
                n_phase = !r_phase;
                if (r_phase) n_state = S_TEST_B;
            end
            S_TEST_B: begin
                o_cmd.sel_b = 1'b1;
                o_cmd.test_b = r_phase;
                n_phase = !r_phase;
                if (r_phase) begin
                    if (i_stat.scan_last) begin
                        n_state = S_DONE;
                        n_phase = 1'b1;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == S_IDLE))
        else $error("load outside idle");
    a_one_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({o_cmd.write, o_cmd.clear, o_cmd.test_b, o_cmd.emit_done}) <= 1)
        else $error("two outputs at once");
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_busy)
        else $error("not busy after load");
`endif

endmodule

/* sv/area_of_interest_range_query.sv */
// Channel | Ports                                     | Handshake
// in      | i_op .. i_range                           | i_start && !o_busy
// out     | o_event_res, o_publisher_id, o_hit_slot,  | o_valid, one cycle
//         | o_last                                    |
// A query scans all 32 slots through one distance unit with a squaring
// register stage, each slot read, squared and tested for area A, then B.
// One word is handled at a time. Reset is synchronous, active low, and
// clears all slot valid bits at once. The receiver cannot stall.
module area_of_interest_range_query
    import aoi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_op,
    input  logic [4:0]  i_slot,
    input  logic [15:0] i_entity_id,
    input  logic [15:0] i_a_min_x,
    input  logic [15:0] i_a_min_y,
    input  logic [15:0] i_a_max_x,
    input  logic [15:0] i_a_max_y,
    input  logic [15:0] i_b_min_x,
    input  logic [15:0] i_b_min_y,
    input  logic [15:0] i_b_max_x,
    input  logic [15:0] i_b_max_y,
    input  logic [15:0] i_range,
    output logic        o_valid,
    output logic [2:0]  o_event_res,
    output logic [15:0] o_publisher_id,
    output logic [4:0]  o_hit_slot,
    output logic        o_last
);

    t_cmd  cmd;
    t_stat stat;

    aoi_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
        .i_stat(stat), .o_cmd(cmd), .o_busy(o_busy)
    );

    aoi_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_op(i_op), .i_slot(i_slot), .i_entity_id(i_entity_id),
        .i_a_min_x(i_a_min_x), .i_a_min_y(i_a_min_y),
        .i_a_max_x(i_a_max_x), .i_a_max_y(i_a_max_y),
        .i_b_min_x(i_b_min_x), .i_b_min_y(i_b_min_y),
        .i_b_max_x(i_b_max_x), .i_b_max_y(i_b_max_y),
        .i_range(i_range), .o_valid(o_valid), .o_event_res(o_event_res),
        .o_publisher_id(o_publisher_id), .o_hit_slot(o_hit_slot), .o_last(o_last)
    );

endmodule

/* sim/area_of_interest_range_query_tb.sv */
`timescale 1ns / 1ps

module area_of_interest_range_query_tb;
    import aoi_pkg::*;

    // One input word and one expected result word.
    typedef struct {
        t_op         op;
        logic [4:0]  slot;
        logic [15:0] id;
        logic [15:0] amnx, amny, amxx, amxy;
        logic [15:0] bmnx, bmny, bmxx, bmxy;
        logic [15:0] rng;
    } t_cmd_word;

    typedef struct {
        t_event      ev;
        logic [15:0] pub;
        logic [4:0]  slot;
        logic        last;
    } t_result_word;

    // Directed row: a command and, where it is obvious, the single result it must give.
    typedef struct {
        t_cmd_word    cmd;
        logic         typed;
        t_result_word want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [2:0]  i_op = '0;
    logic [4:0]  i_slot = '0;
    logic [15:0] i_entity_id = '0;
    logic [15:0] i_a_min_x = '0, i_a_min_y = '0, i_a_max_x = '0, i_a_max_y = '0;
    logic [15:0] i_b_min_x = '0, i_b_min_y = '0, i_b_max_x = '0, i_b_max_y = '0;
    logic [15:0] i_range = '0;
    logic        o_valid;
    logic [2:0]  o_event_res;
    logic [15:0] o_publisher_id;
    logic [4:0]  o_hit_slot;
    logic        o_last;

    // Shadow copy of the publisher table.
    logic        tbl_valid [TableDepth];
    logic        tbl_area  [TableDepth];
    logic [15:0] tbl_id    [TableDepth];
    logic [15:0] tbl_mnx [TableDepth], tbl_mny [TableDepth];
    logic [15:0] tbl_mxx [TableDepth], tbl_mxy [TableDepth];

    t_result_word pending_results[$];
    int errors = 0;
    int cycles = 0;
    int words_sent = 0;
    int results_seen = 0;
    int hits_seen = 0;

    area_of_interest_range_query DUT (.*);

    always #5 i_clk = ~i_clk;

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("MISMATCH at cycle %0d: %s", cycles, what);
    endtask

    // Append one expected word at the tail of the queue.
    task automatic queue_result(input t_result_word w);
        pending_results.insert(pending_results.size(), w);
    endtask

    // Compare each result word with the oldest pending expectation.
    always @(posedge i_clk) begin
        t_result_word w;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected word ev=%0d id=%0h slot=%0d",
                    o_event_res, o_publisher_id, o_hit_slot));
            end else begin
                w = pending_results.pop_front();
                if (w.ev == EV_HIT || w.ev == EV_ENTER || w.ev == EV_LEAVE) hits_seen++;
                if (o_event_res !== w.ev || o_publisher_id !== w.pub ||
                    o_hit_slot !== w.slot || o_last !== w.last)
                    report_mismatch($sformatf(
                        "got ev=%0d id=%0h slot=%0d last=%0b, want ev=%0d id=%0h slot=%0d last=%0b",
                        o_event_res, o_publisher_id, o_hit_slot, o_last,
                        w.ev, w.pub, w.slot, w.last));
            end
        end
    end

    function automatic logic near_point(input logic [15:0] px, py, cx, cy,
                                        input logic [15:0] r);
        logic [33:0] dx, dy;
        dx = (px > cx) ? px - cx : cx - px;
        dy = (py > cy) ? py - cy : cy - py;
        return (dx * dx + dy * dy) <= ({18'd0, r} * {18'd0, r});
    endfunction

    // Point against a box grown by r with rounded corners.
    function automatic logic near_rounded_box(input logic [15:0] px, py,
            mnx, mny, mxx, mxy, input logic [15:0] r);
        int signed x, y;
        x = px;
        y = py;
        if (x < int'(mnx) - int'(r) || x > int'(mxx) + int'(r) ||
            y < int'(mny) - int'(r) || y > int'(mxy) + int'(r))
            return 1'b0;
        if (px <= mnx && py <= mny) return near_point(px, py, mnx, mny, r);
        if (px <= mnx && py >= mxy) return near_point(px, py, mnx, mxy, r);
        if (px >= mxx && py <= mny) return near_point(px, py, mxx, mny, r);
        if (px >= mxx && py >= mxy) return near_point(px, py, mxx, mxy, r);
        return 1'b1;
    endfunction

    function automatic logic slot_in_interest(input int i, input logic rect,
            input logic [15:0] mnx, mny, mxx, mxy, own, r);
        if (!tbl_valid[i] || tbl_id[i] == own) return 1'b0;
        if (rect) begin
            if (tbl_area[i]) return 1'b0;
            return near_rounded_box(tbl_mnx[i], tbl_mny[i], mnx, mny, mxx, mxy, r);
        end
        if (tbl_area[i])
            return near_rounded_box(mnx, mny, tbl_mnx[i], tbl_mny[i], tbl_mxx[i],
                                    tbl_mxy[i], r);
        return near_point(mnx, mny, tbl_mnx[i], tbl_mny[i], r);
    endfunction

    function automatic t_result_word mk(input t_event ev, input logic [15:0] pub,
                                        input logic [4:0] slot, input logic last);
        t_result_word w;
        w.ev = ev;
        w.pub = pub;
        w.slot = slot;
        w.last = last;
        return w;
    endfunction

    // Update the shadow table and queue the results of one command word.
    task automatic predict_interest(input t_cmd_word c);
        logic now_in, was_in, rect;
        rect = (c.op == OP_Q_RECT || c.op == OP_MV_RECT);
        case (c.op)
            OP_WR_PT, OP_WR_RECT: begin
                tbl_valid[c.slot] = 1'b1;
                tbl_area[c.slot] = (c.op == OP_WR_RECT);
                tbl_id[c.slot] = c.id;
                tbl_mnx[c.slot] = c.amnx;
                tbl_mny[c.slot] = c.amny;
                tbl_mxx[c.slot] = (c.op == OP_WR_PT) ? c.amnx : c.amxx;
                tbl_mxy[c.slot] = (c.op == OP_WR_PT) ? c.amny : c.amxy;
                queue_result(mk(EV_DONE, c.id, c.slot, 1'b1));
            end
            OP_CLEAR: begin
                if (tbl_valid[c.slot]) begin
                    tbl_valid[c.slot] = 1'b0;
                    queue_result(mk(EV_DONE, tbl_id[c.slot], c.slot, 1'b1));
                end else begin
                    queue_result(mk(EV_EMPTY, 16'd0, c.slot, 1'b1));
                end
            end
            OP_Q_PT, OP_Q_RECT: begin
                for (int i = 0; i < TableDepth; i++)
                    if (slot_in_interest(i, rect, c.amnx, c.amny, c.amxx, c.amxy,
                                         c.id, c.rng))
                        queue_result(mk(EV_HIT, tbl_id[i], 5'(i), 1'b0));
                queue_result(mk(EV_DONE, 16'd0, 5'd0, 1'b1));
            end
            OP_MV_PT, OP_MV_RECT: begin
                for (int i = 0; i < TableDepth; i++) begin
                    now_in = slot_in_interest(i, rect, c.amnx, c.amny, c.amxx, c.amxy,
                                              c.id, c.rng);
                    was_in = slot_in_interest(i, rect, c.bmnx, c.bmny, c.bmxx, c.bmxy,
                                              c.id, c.rng);
                    if (now_in && !was_in)
                        queue_result(mk(EV_ENTER, tbl_id[i], 5'(i), 1'b0));
                    else if (was_in && !now_in)
                        queue_result(mk(EV_LEAVE, tbl_id[i], 5'(i), 1'b0));
                end
                queue_result(mk(EV_DONE, 16'd0, 5'd0, 1'b1));
            end
            default: queue_result(mk(EV_DONE, 16'd0, 5'd0, 1'b1));
        endcase
    endtask

    // Present one word and hold it until the block takes it.
    task automatic send_word(input t_cmd_word c);
        i_start <= 1'b1;
        i_op <= c.op;
        i_slot <= c.slot;
        i_entity_id <= c.id;
        i_a_min_x <= c.amnx;
        i_a_min_y <= c.amny;
        i_a_max_x <= c.amxx;
        i_a_max_y <= c.amxy;
        i_b_min_x <= c.bmnx;
        i_b_min_y <= c.bmny;
        i_b_max_x <= c.bmxx;
        i_b_max_y <= c.bmxy;
        i_range <= c.rng;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_interest(c);
        words_sent++;
    endtask

    task automatic idle_burst();
        i_start <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge i_clk);
    endtask

    function automatic t_cmd_word word_of(input t_op op, input int slot, id,
            input int ax, ay, bx, by, input int r);
        t_cmd_word c;
        c.op = op;
        c.slot = 5'(slot);
        c.id = 16'(id);
        c.amnx = 16'(ax);
        c.amny = 16'(ay);
        c.amxx = 16'(bx);
        c.amxy = 16'(by);
        c.bmnx = '0;
        c.bmny = '0;
        c.bmxx = '0;
        c.bmxy = '0;
        c.rng = 16'(r);
        return c;
    endfunction

    // Random coordinates clustered near a center so hits are common.
    function automatic logic [15:0] near_coord(input logic [15:0] ctr);
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return 16'(32'(ctr) + $urandom_range(0, 600) - 32'd300);
    endfunction

    function automatic t_cmd_word random_word(input logic [15:0] cx, cy);
        t_cmd_word c;
        int k;
        k = $urandom_range(0, 99);
        if (k < 30) c.op = ($urandom_range(0, 1) != 0) ? OP_WR_RECT : OP_WR_PT;
        else if (k < 40) c.op = OP_CLEAR;
        else if (k < 55) c.op = OP_Q_PT;
        else if (k < 65) c.op = OP_Q_RECT;
        else if (k < 80) c.op = OP_MV_PT;
        else if (k < 97) c.op = OP_MV_RECT;
        else c.op = OP_NONE;
        c.slot = 5'($urandom);
        c.id = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
        c.amnx = near_coord(cx);
        c.amny = near_coord(cy);
        c.amxx = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                             : 16'(32'(c.amnx) + $urandom_range(0, 200));
        c.amxy = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                             : 16'(32'(c.amny) + $urandom_range(0, 200));
        c.bmnx = near_coord(cx);
        c.bmny = near_coord(cy);
        c.bmxx = 16'(32'(c.bmnx) + $urandom_range(0, 200));
        c.bmxy = 16'(32'(c.bmny) + $urandom_range(0, 200));
        c.rng = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
        return c;
    endfunction

    t_row directed_rows[$];

    // Append one row to the directed table.
    task automatic add_row(input t_row r);
        directed_rows.insert(directed_rows.size(), r);
    endtask

    initial begin
        t_row row;
        t_cmd_word c;
        logic [15:0] cx, cy;
        int rnd_count;

        for (int i = 0; i < TableDepth; i++) tbl_valid[i] = 1'b0;

        // Directed table: typed results only for the obvious cases.
        row.typed = 1'b1;
        row.cmd = word_of(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        row.want = mk(EV_EMPTY, 16'd0, 5'd0, 1'b1);
        add_row(row);
        row.cmd = word_of(OP_CLEAR, 31, 16'hffff, 0, 0, 0, 0, 0);
        row.want = mk(EV_EMPTY, 16'd0, 5'd31, 1'b1);
        add_row(row);
        row.cmd = word_of(OP_Q_PT, 0, 1, 100, 100, 0, 0, 16'hffff);
        row.want = mk(EV_DONE, 16'd0, 5'd0, 1'b1);
        add_row(row);
        row.cmd = word_of(OP_WR_PT, 0, 16'hffff, 0, 0, 0, 0, 0);
        row.want = mk(EV_DONE, 16'hffff, 5'd0, 1'b1);
        add_row(row);
        row.cmd = word_of(OP_WR_RECT, 31, 16'h1234, 16'hffff, 16'hffff, 16'hffff,
                          16'hffff, 0);
        row.want = mk(EV_DONE, 16'h1234, 5'd31, 1'b1);
        add_row(row);
        row.cmd = word_of(OP_NONE, 7, 9, 1, 1, 1, 1, 1);
        row.want = mk(EV_DONE, 16'd0, 5'd0, 1'b1);
        add_row(row);
        row.typed = 1'b0;
        // Rectangle, an inverted rectangle, a duplicate id and a point near a corner.
        add_row('{word_of(OP_WR_RECT, 1, 5, 100, 100, 200, 200, 0), 0, row.want});
        add_row('{word_of(OP_WR_RECT, 2, 6, 300, 300, 250, 250, 0), 0, row.want});
        add_row('{word_of(OP_WR_PT, 3, 5, 150, 150, 0, 0, 0), 0, row.want});
        add_row('{word_of(OP_WR_PT, 4, 7, 0, 65535, 0, 0, 0), 0, row.want});
        // Corner exactly on the rounded edge: 3-4-5 triangle off the min/min corner.
        add_row('{word_of(OP_Q_PT, 0, 1, 97, 96, 0, 0, 5), 0, row.want});
        add_row('{word_of(OP_Q_PT, 0, 1, 96, 96, 0, 0, 5), 0, row.want});
        add_row('{word_of(OP_Q_PT, 0, 5, 150, 150, 0, 0, 100), 0, row.want});
        add_row('{word_of(OP_Q_PT, 0, 1, 0, 0, 0, 0, 16'hffff), 0, row.want});
        add_row('{word_of(OP_Q_PT, 0, 1, 16'hffff, 16'hffff, 0, 0, 0), 0, row.want});
        add_row('{word_of(OP_Q_RECT, 0, 2, 140, 140, 160, 160, 0), 0, row.want});
        add_row('{word_of(OP_Q_RECT, 0, 2, 0, 0, 16'hffff, 16'hffff, 16'hffff),
                  0, row.want});
        c = word_of(OP_MV_PT, 0, 2, 150, 150, 0, 0, 10);
        c.bmnx = 16'd5000;
        c.bmny = 16'd5000;
        add_row('{c, 0, row.want});
        c.amnx = 16'd5000;
        c.amny = 16'd5000;
        c.bmnx = 16'd150;
        c.bmny = 16'd150;
        add_row('{c, 0, row.want});
        c = word_of(OP_MV_RECT, 0, 2, 0, 0, 16'hffff, 16'hffff, 1);
        c.bmnx = 16'd140;
        c.bmny = 16'd140;
        c.bmxx = 16'd145;
        c.bmxy = 16'd145;
        add_row('{c, 0, row.want});
        add_row('{word_of(OP_CLEAR, 1, 0, 0, 0, 0, 0, 0), 0, row.want});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            if (directed_rows[n].typed) begin
                // A typed row must be the only word in flight.
                i_start <= 1'b0;
                @(posedge i_clk);
                while (pending_results.size() != 0) @(posedge i_clk);
                send_word(directed_rows[n].cmd);
                void'(pending_results.pop_back());
                queue_result(directed_rows[n].want);
            end else begin
                send_word(directed_rows[n].cmd);
            end
            if ($urandom_range(0, 2) == 0) idle_burst();
        end

        // Random part: mixed traffic near a shared center.
        cx = 16'($urandom_range(400, 65000));
        cy = 16'($urandom_range(400, 65000));
        rnd_count = 0;
        while (rnd_count < 130) begin
            c = random_word(cx, cy);
            if (rnd_count == 65) begin
                // Let the block drain completely before carrying on.
                i_start <= 1'b0;
                @(posedge i_clk);
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            send_word(c);
            rnd_count++;
            if (rnd_count < 105 && $urandom_range(0, 3) == 0) idle_burst();
        end
        i_start <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        $display("Sent %0d command words; checked %0d result words, %0d of them hits",
                 words_sent, results_seen, hits_seen);
        $display("covering writes, clears, point and rectangle queries and moves.");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
